>>> rtl/key_tap_hold_gesture_fsm_top_macros.svh
// Assertion macros for the key tap/hold gesture block.
// Used by the port checker; needs nothing else.
`ifndef KEY_TAP_HOLD_GESTURE_FSM_TOP_MACROS_SVH
`define KEY_TAP_HOLD_GESTURE_FSM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define KTHG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gesture check failed");

// Next-cycle implication, disabled while reset is held.
`define KTHG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gesture check failed");

`endif

>>> rtl/kthg_pkg.sv
// Shared types and constants of the key tap/hold gesture block.
// No dependencies.
`default_nettype none

package kthg_pkg;

  localparam int unsigned TIME_WIDTH_DEFAULT = 32;
  localparam int unsigned NOW_WIDTH          = 32;
  localparam int unsigned CFG_DATA_WIDTH     = 16;
  localparam int unsigned CFG_INDEX_WIDTH    = 2;

  localparam logic [15:0] HOLD_THRESHOLD_RESET = 16'd350;
  localparam logic [15:0] TAP_WINDOW_RESET     = 16'd400;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRESSED = 3'd1,
    PH_AWAIT   = 3'd2,
    PH_LATCHED = 3'd3,
    PH_DRAIN   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    FN_KEY_DOWN = 2'd0,
    FN_KEY_UP   = 2'd1,
    FN_EXPIRY   = 2'd2,
    FN_CANCEL   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_COMMIT  = 2'd1,
    ACT_DISCARD = 2'd2
  } action_e;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_DOUBLE_TAP = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_HOLD       = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_WINDOW     = 2'd2;

  typedef struct packed {
    logic        double_tap_mode;
    logic [15:0] hold_threshold_ticks;
    logic [15:0] tap_window_ticks;
  } cfg_t;

  typedef struct packed {
    logic        action_valid;
    action_e     action;
    logic        active;
    logic        deadline_pending;
    logic [31:0] pending_deadline;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/kthg_cfg_regs.sv
// Configuration register file of the key tap/hold gesture block.
// Depends on kthg_pkg.
`default_nettype none

module kthg_cfg_regs
  import kthg_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data_i,
  output cfg_t                            cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_DOUBLE_TAP: cfg_d.double_tap_mode      = cfg_data_i[0];
        CFG_IDX_HOLD:       cfg_d.hold_threshold_ticks = cfg_data_i;
        CFG_IDX_WINDOW:     cfg_d.tap_window_ticks     = cfg_data_i;
        default:            cfg_d = cfg_q;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.double_tap_mode      <= 1'b0;
      cfg_q.hold_threshold_ticks <= HOLD_THRESHOLD_RESET;
      cfg_q.tap_window_ticks     <= TAP_WINDOW_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/kthg_gesture.sv
// Gesture phase machine: state registers, next-state and result logic.
// Depends on kthg_pkg.
`default_nettype none

module kthg_gesture
  import kthg_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire func_e                 func_i,
  input  wire logic [TIME_WIDTH-1:0] now_i,
  input  wire cfg_t                  cfg_i,
  output result_t                    result_o
);

  localparam int unsigned OUT_BITS = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;

  phase_e                phase_q, phase_d;
  logic [TIME_WIDTH-1:0] press_time_q, press_time_d;
  logic [1:0]            tap_count_q, tap_count_d;
  logic [TIME_WIDTH-1:0] tap_deadline_q, tap_deadline_d;
  logic                  act;
  action_e               code;

  logic [TIME_WIDTH-1:0] held;
  logic [TIME_WIDTH-1:0] since_deadline;
  logic [1:0]            taps_needed;
  logic                  is_hold;
  logic                  expired;

  // Wrapping differences, read as signed.
  assign held           = now_i - press_time_q;
  assign since_deadline = now_i - tap_deadline_q;
  assign taps_needed    = cfg_i.double_tap_mode ? 2'd2 : 2'd1;
  assign is_hold        = !held[TIME_WIDTH-1] &&
                          (held >= TIME_WIDTH'(cfg_i.hold_threshold_ticks));
  assign expired        = !since_deadline[TIME_WIDTH-1];

  // Next state and action of the event.
  always_comb begin
    phase_d        = phase_q;
    press_time_d   = press_time_q;
    tap_count_d    = tap_count_q;
    tap_deadline_d = tap_deadline_q;
    act            = 1'b0;
    code           = ACT_START;
    unique case (func_i)
      FN_KEY_DOWN: begin
        priority if (phase_q == PH_IDLE) begin
          phase_d      = PH_PRESSED;
          press_time_d = now_i;
          tap_count_d  = 2'd1;
          act          = 1'b1;
          code         = ACT_START;
        end else if (phase_q == PH_AWAIT) begin
          phase_d      = PH_PRESSED;
          press_time_d = now_i;
          tap_count_d  = 2'd2;
        end else if (phase_q == PH_LATCHED) begin
          phase_d = PH_DRAIN;
          act     = 1'b1;
          code    = ACT_COMMIT;
        end else begin
          phase_d = phase_q;
        end
      end
      FN_KEY_UP: begin
        priority if (phase_q == PH_PRESSED) begin
          priority if (is_hold) begin
            phase_d = PH_IDLE;
            act     = 1'b1;
            code    = ACT_COMMIT;
          end else if (tap_count_q >= taps_needed) begin
            phase_d = PH_LATCHED;
          end else begin
            phase_d        = PH_AWAIT;
            tap_deadline_d = now_i + TIME_WIDTH'(cfg_i.tap_window_ticks);
          end
        end else if (phase_q == PH_DRAIN) begin
          phase_d = PH_IDLE;
        end else begin
          phase_d = phase_q;
        end
      end
      FN_EXPIRY: begin
        if (phase_q == PH_AWAIT && expired) begin
          phase_d = PH_IDLE;
          act     = 1'b1;
          code    = ACT_DISCARD;
        end
      end
      FN_CANCEL: begin
        if (phase_q != PH_IDLE) begin
          act  = 1'b1;
          code = ACT_DISCARD;
        end
        phase_d = PH_IDLE;
      end
      default: phase_d = phase_q;
    endcase
  end

  // Result fields follow the phase after the event.
  always_comb begin
    result_o.action_valid     = act;
    result_o.action           = act ? code : ACT_START;
    result_o.active           = (phase_d != PH_IDLE);
    result_o.deadline_pending = (phase_d == PH_AWAIT);
    result_o.pending_deadline = (phase_d == PH_AWAIT) ?
                                32'(tap_deadline_d[OUT_BITS-1:0]) : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      press_time_q   <= '0;
      tap_count_q    <= 2'd0;
      tap_deadline_q <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      press_time_q   <= press_time_d;
      tap_count_q    <= tap_count_d;
      tap_deadline_q <= tap_deadline_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/key_tap_hold_gesture_fsm_top.sv
// Key tap/hold gesture block: requests pass an input register, then a result register.
// Throughput one request per cycle when results are not stalled; the phase update is
// a single subtract-compare between the two registers, so back-to-back requests flow.
// A stalled result register holds; the input register then takes one more request.
// Reset (rst_ni, asynchronous, active low) clears phase, times, tap count and valids,
// and sets the registers to single-tap mode, 350-tick hold and 400-tick window.
`default_nettype none

module key_tap_hold_gesture_fsm_top
  import kthg_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request stream
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [31:0]                s_axis_tdata,  // [31:0] now
  input  wire logic [1:0]                 s_axis_tuser,  // [1:0] func
  // result stream
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [0] active, [1] deadline_pending, [33:2] pending_deadline, [39:34] zero
  output logic [39:0]                     m_axis_tdata,
  // [0] action_valid, [2:1] action
  output logic [2:0]                      m_axis_tuser,
  // configuration writes
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  // Only the low bits of the tick counter that fit the internal time width are used.
  localparam int unsigned IN_BITS = (TIME_WIDTH < NOW_WIDTH) ? TIME_WIDTH : NOW_WIDTH;

  cfg_t                  cfg;
  result_t               result;

  // Input register.
  logic                  in_valid_q, in_valid_d;
  func_e                 func_q;
  logic [TIME_WIDTH-1:0] now_q;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  result_t               out_q;

  logic                  in_fire;
  logic                  step;

  // Advance the input stage whenever the result register is free or being drained.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign in_valid_d  = in_fire || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request: keep the usable low bits of the time stamp.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_e'(s_axis_tuser);
      now_q  <= TIME_WIDTH'(s_axis_tdata[IN_BITS-1:0]);
    end
  end

  // Hold the result until the consumer takes it.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  kthg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kthg_gesture #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_gesture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .func_i   (func_q),
    .now_i    (now_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.pending_deadline, out_q.deadline_pending, out_q.active};
  assign m_axis_tuser  = {out_q.action, out_q.action_valid};

endmodule

`default_nettype wire

>>> rtl/kthg_port_checker.sv
// Port-level checks of the key tap/hold gesture block, bound to the top level.
// Depends on key_tap_hold_gesture_fsm_top_macros.svh and kthg_pkg.
`default_nettype none
`include "key_tap_hold_gesture_fsm_top_macros.svh"

module kthg_port_checker
  import kthg_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  `KTHG_ASSERT_IMPL(a_no_action_code, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tuser[2:1] == ACT_START)
  `KTHG_ASSERT_IMPL(a_deadline_cleared, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[1], m_axis_tdata[33:2] == 32'd0)
  `KTHG_ASSERT_IMPL(a_await_is_active, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0])
  `KTHG_ASSERT_IMPL(a_discard_goes_idle, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] && (m_axis_tuser[2:1] == ACT_DISCARD), !m_axis_tdata[0])
  `KTHG_ASSERT_NEXT(a_result_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind key_tap_hold_gesture_fsm_top kthg_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/sv/key_tap_hold_gesture_fsm_top_test.sv
// Self-checking testbench for the key tap/hold gesture block: directed gestures, then
// random key event streams under several register settings and handshake idling.
// Depends on kthg_pkg and key_tap_hold_gesture_fsm_top.

module key_tap_hold_gesture_fsm_top_test;
  import kthg_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 3000; // cycles with no handshake at all
  localparam int unsigned STALL_AT      = 60;   // result count that starts the long hold-off
  localparam int unsigned STALL_CYCLES  = 64;
  localparam int unsigned PHASE_EVENTS  = 105;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam int unsigned TAIL_CYCLES   = 8;

  // One key event as offered on the request stream.
  typedef struct {
    func_e       fn;
    logic [31:0] stamp;
  } key_event_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;        // [31:0] now
  logic [1:0]  s_axis_tuser  = FN_KEY_DOWN; // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] active, [1] deadline_pending, [33:2] pending_deadline, [39:34] zero
  logic [39:0] m_axis_tdata;
  // [0] action_valid, [2:1] action
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i = CFG_IDX_DOUBLE_TAP;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i  = '0;

  key_event_t  pending_events[$];     // events waiting for the driver
  result_t     expected_outcomes[$];  // predicted results, oldest first

  // Predictor copy of the registers and the gesture state.
  logic        cfg_double_tap   = 1'b0;
  logic [15:0] cfg_hold_ticks   = HOLD_THRESHOLD_RESET;
  logic [15:0] cfg_window_ticks = TAP_WINDOW_RESET;
  phase_e      gest_phase       = PH_IDLE;
  logic [31:0] press_stamp      = '0;
  logic [1:0]  tap_count        = '0;
  logic [31:0] tap_deadline     = '0;

  // Idling percentages, changed by the stimulus between phases.
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 80;

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned stall_left    = 0;
  int unsigned quiet_cycles  = 0;

  // Random event generator state: running time stamp and whether the key is down.
  logic [31:0] gen_now  = '0;
  logic        gen_held = 1'b0;

  key_tap_hold_gesture_fsm_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Hold reset at the start, then release it for good.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Advance the gesture state by one event and return the result it yields.
  // Times compare by wrapping subtraction read as signed; a negative press
  // duration therefore counts as a short tap.
  function automatic result_t predict_gesture(func_e fn, logic [31:0] now);
    result_t     res;
    logic [31:0] held;
    logic [31:0] late;
    logic [1:0]  taps_needed;
    logic        fired;
    action_e     act;
    fired = 1'b0;
    act   = ACT_START;
    case (fn)
      FN_KEY_DOWN: begin
        if (gest_phase == PH_IDLE) begin
          gest_phase  = PH_PRESSED;
          press_stamp = now;
          tap_count   = 2'd1;
          fired       = 1'b1;
          act         = ACT_START;
        end else if (gest_phase == PH_AWAIT) begin
          // second tap: no action until its release
          gest_phase  = PH_PRESSED;
          press_stamp = now;
          tap_count   = 2'd2;
        end else if (gest_phase == PH_LATCHED) begin
          gest_phase = PH_DRAIN;
          fired      = 1'b1;
          act        = ACT_COMMIT;
        end
      end
      FN_KEY_UP: begin
        if (gest_phase == PH_PRESSED) begin
          held        = now - press_stamp;
          // the tap count needed is read at release, so a mode change mid-gesture counts
          taps_needed = cfg_double_tap ? 2'd2 : 2'd1;
          if (!held[31] && held >= {16'd0, cfg_hold_ticks}) begin
            gest_phase = PH_IDLE;
            fired      = 1'b1;
            act        = ACT_COMMIT;
          end else if (tap_count >= taps_needed) begin
            gest_phase = PH_LATCHED;
          end else begin
            gest_phase   = PH_AWAIT;
            tap_deadline = now + {16'd0, cfg_window_ticks};
          end
        end else if (gest_phase == PH_DRAIN) begin
          gest_phase = PH_IDLE;
        end
      end
      FN_EXPIRY: begin
        late = now - tap_deadline;
        if (gest_phase == PH_AWAIT && !late[31]) begin
          gest_phase = PH_IDLE;
          fired      = 1'b1;
          act        = ACT_DISCARD;
        end
      end
      default: begin
        if (gest_phase != PH_IDLE) begin
          fired = 1'b1;
          act   = ACT_DISCARD;
        end
        gest_phase = PH_IDLE;
      end
    endcase
    res.action_valid     = fired;
    res.action           = fired ? act : ACT_START;
    res.active           = (gest_phase != PH_IDLE);
    res.deadline_pending = (gest_phase == PH_AWAIT);
    res.pending_deadline = (gest_phase == PH_AWAIT) ? tap_deadline : 32'd0;
    return res;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, field, got, want);
    mismatches++;
  endtask

  // Request driver: predict each accepted request, then offer the next one
  // unless the sender is idling this cycle. Valid stays up until accepted.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    key_event_t next_ev;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_outcomes.push_back(predict_gesture(func_e'(s_axis_tuser), s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_ev = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_ev.stamp;
          s_axis_tuser  <= next_ev.fn;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result against the oldest prediction,
  // and drive ready with random idling plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = expected_outcomes.pop_front();
          if (m_axis_tuser[0] !== want.action_valid)
            report_mismatch("action_valid", 32'(m_axis_tuser[0]), 32'(want.action_valid));
          if (m_axis_tuser[2:1] !== want.action)
            report_mismatch("action", 32'(m_axis_tuser[2:1]), 32'(want.action));
          if (m_axis_tdata[0] !== want.active)
            report_mismatch("active", 32'(m_axis_tdata[0]), 32'(want.active));
          if (m_axis_tdata[1] !== want.deadline_pending)
            report_mismatch("deadline_pending", 32'(m_axis_tdata[1]),
                            32'(want.deadline_pending));
          if (m_axis_tdata[33:2] !== want.pending_deadline)
            report_mismatch("pending_deadline", m_axis_tdata[33:2], want.pending_deadline);
        end
        // start the long hold-off once, so the pipeline backs up into the input
        if (results_seen == STALL_AT)
          stall_left = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_event(func_e fn, logic [31:0] stamp);
    key_event_t ev;
    ev.fn    = fn;
    ev.stamp = stamp;
    pending_events.push_back(ev);
  endtask

  // Hold until every queued request is accepted and every result has come back.
  task automatic wait_drained();
    wait (pending_events.size() == 0 && !s_axis_tvalid && expected_outcomes.size() == 0);
    @(posedge clk_i);
  endtask

  // Write one register while the block is idle and mirror it in the predictor;
  // for the mode register only bit 0 of the data counts.
  task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_IDX_DOUBLE_TAP: cfg_double_tap   = data[0];
      CFG_IDX_HOLD:       cfg_hold_ticks   = data;
      CFG_IDX_WINDOW:     cfg_window_ticks = data;
      default: ;
    endcase
  endtask

  // Queue one random event. Mostly well-formed: a held key is usually released,
  // a free key usually pressed or checked for expiry. Time steps scale with the
  // hold threshold or the tap window so both sides of each limit are reached.
  task automatic push_random_event();
    int unsigned r;
    func_e       fn;
    int unsigned span;
    r = $urandom_range(0, 99);
    if (gen_held) begin
      if (r < 85)      fn = FN_KEY_UP;
      else if (r < 92) fn = FN_KEY_DOWN;
      else if (r < 97) fn = FN_EXPIRY;
      else             fn = FN_CANCEL;
    end else begin
      if (r < 60)      fn = FN_KEY_DOWN;
      else if (r < 85) fn = FN_EXPIRY;
      else if (r < 92) fn = FN_KEY_UP;
      else             fn = FN_CANCEL;
    end
    span = (fn == FN_KEY_UP) ? 2 * cfg_hold_ticks + 2 : 2 * cfg_window_ticks + 2;
    // now and then jump anywhere, backwards included, to wrap the time stamp
    if ($urandom_range(0, 99) < 3)
      gen_now = $urandom();
    else
      gen_now = gen_now + $urandom_range(0, span);
    if (fn == FN_KEY_DOWN)
      gen_held = 1'b1;
    else if (fn != FN_EXPIRY)
      gen_held = 1'b0;
    push_event(fn, gen_now);
  endtask

  initial begin : stimulus
    logic [15:0] hold_val;
    logic [15:0] window_val;
    logic [15:0] mode_val;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed part, reset settings: single tap, 350-tick hold, 400-tick window.
    push_event(FN_CANCEL,   32'd0);    // cancel while idle: no action
    push_event(FN_KEY_UP,   32'd0);    // release while idle: ignored
    push_event(FN_EXPIRY,   32'd0);    // expiry check outside await: ignored
    push_event(FN_KEY_DOWN, 32'd100);  // start recording
    push_event(FN_KEY_DOWN, 32'd120);  // press while pressed: ignored
    push_event(FN_KEY_UP,   32'd449);  // one tick short of hold: latch
    push_event(FN_KEY_UP,   32'd450);  // release while latched: ignored
    push_event(FN_KEY_DOWN, 32'd500);  // press while latched: commit
    push_event(FN_KEY_DOWN, 32'd510);  // press while draining: ignored
    push_event(FN_KEY_UP,   32'd520);  // back to idle
    push_event(FN_KEY_DOWN, 32'd1000);
    push_event(FN_KEY_UP,   32'd1350); // exactly the hold threshold: commit
    push_event(FN_KEY_DOWN, 32'd1000);
    push_event(FN_KEY_UP,   32'd500);  // negative duration reads as a short tap
    push_event(FN_CANCEL,   32'd600);  // cancel while latched: discard

    // Double-tap mode, written with all data bits set.
    write_register(CFG_IDX_DOUBLE_TAP, 16'hFFFF);
    push_event(FN_KEY_DOWN, 32'hFFFF_FF00);
    push_event(FN_KEY_UP,   32'hFFFF_FF10); // deadline wraps past zero
    push_event(FN_EXPIRY,   32'hFFFF_FF20); // deadline not yet reached
    push_event(FN_KEY_DOWN, 32'h0000_0050); // second tap
    push_event(FN_KEY_UP,   32'h0000_0060); // latch
    push_event(FN_CANCEL,   32'h0000_0070);
    push_event(FN_KEY_DOWN, 32'd0);
    push_event(FN_KEY_UP,   32'd5);
    push_event(FN_EXPIRY,   32'd405);       // exactly at the deadline: discard
    push_event(FN_KEY_DOWN, 32'd2000);

    // Switch to single tap while the key is down; the release must latch.
    write_register(CFG_IDX_DOUBLE_TAP, 16'h0000);
    push_event(FN_KEY_UP,   32'd2010);
    push_event(FN_CANCEL,   32'd2020);

    // Random phases: idle profile sender 15 / receiver 80, then swapped, then none.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin mode_val = 16'd0; hold_val = 16'd350;   window_val = 16'd400;   end
        1:       begin mode_val = 16'd1; hold_val = 16'd0;     window_val = 16'd0;     end
        2:       begin mode_val = 16'd1; hold_val = 16'hFFFF;  window_val = 16'hFFFF;  end
        3:       begin mode_val = 16'd0; hold_val = 16'hFFFF;  window_val = 16'd0;     end
        4:       begin mode_val = 16'd1; hold_val = 16'd1;     window_val = 16'hFFFF;  end
        default: begin
          mode_val   = 16'($urandom());
          hold_val   = 16'($urandom_range(0, 1000));
          window_val = 16'($urandom_range(0, 1000));
        end
      endcase
      write_register(CFG_IDX_DOUBLE_TAP, mode_val);
      write_register(CFG_IDX_HOLD,       hold_val);
      write_register(CFG_IDX_WINDOW,     window_val);
      if (ph < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 80;
      end else if (ph < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int unsigned n = 0; n < PHASE_EVENTS; n++)
        push_random_event();
      // pause the sender until every result of this phase is back
      wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
